### rtl/tfn_pkg.sv
// Package for the triangle face normal block.
// Holds fixed field widths, the channel payload types and the reset value of min_length.
// Used by rtl/triangle_face_normal.sv and bench/triangle_face_normal_tb.sv.
package tfn_pkg;

  // Fixed widths of the external fields.
  localparam int COORD_W   = 32;
  localparam int OUT_W     = 32;
  localparam int MIN_LEN_W = 32;

  // Internal widths of the exact cross product datapath.
  localparam int DIFF_W    = COORD_W + 1;        // edge vector component
  localparam int PROD_W    = 2 * DIFF_W;         // one signed product
  localparam int CROSS_W   = PROD_W + 1;         // cross product component
  localparam int MAG_W     = CROSS_W - 1;        // its magnitude
  localparam int LO_W      = 32;                 // low slice for squaring
  localparam int HI_W      = MAG_W - LO_W;       // high slice for squaring
  localparam int SUMSQ_W   = 2 * MAG_W;          // sum of three squares
  localparam int ROOT_W    = SUMSQ_W / 2;        // integer square root
  localparam int SREM_W    = ROOT_W + 3;         // square root remainder
  localparam int DREM_W    = ROOT_W + 1;         // divider remainder
  localparam int SQRT_STEPS = ROOT_W;            // one root bit per stage

  localparam logic [MIN_LEN_W-1:0] MIN_LENGTH_RESET = 32'd42950;

  // One triangle: three vertices in signed fixed point.
  typedef struct packed {
    logic signed [COORD_W-1:0] a_x;
    logic signed [COORD_W-1:0] a_y;
    logic signed [COORD_W-1:0] a_z;
    logic signed [COORD_W-1:0] b_x;
    logic signed [COORD_W-1:0] b_y;
    logic signed [COORD_W-1:0] b_z;
    logic signed [COORD_W-1:0] c_x;
    logic signed [COORD_W-1:0] c_y;
    logic signed [COORD_W-1:0] c_z;
  } tri_t;

  // One face normal and its flag.
  typedef struct packed {
    logic signed [OUT_W-1:0] normal_x;
    logic signed [OUT_W-1:0] normal_y;
    logic signed [OUT_W-1:0] normal_z;
    logic                    normalized;
  } norm_t;

endpackage

### rtl/tfn_stream_if.sv
// Valid/ready stream interface for the triangle face normal block.
// The payload type is a parameter; the block uses tri_t and norm_t from tfn_pkg.
interface tfn_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### rtl/triangle_face_normal.sv
// Triangle face normal: exact cross product, length, unit normal in fixed point.
// Depends on tfn_pkg (widths, payload types) and tfn_stream_if (channels).
//
//   channel    dir  handshake          payload
//   vertices   in   valid/ready        tri_t : a_x .. c_z, signed Q16.16
//   normal     out  valid/ready        norm_t: normal_x/y/z Q2.30, normalized
//   cfg        in   cfg_we/cfg_wdata   min_length, 32 bits unsigned
//
// One transaction is accepted per cycle unless the output stalls. Each passes the
// front stages, the square root pipeline (one root bit per stage) and
// the divider pipeline (one quotient bit per stage). Reset clears all valid bits
// and loads min_length with 42950. When a result waits at the output, the whole
// pipeline holds, and no transaction is lost or repeated.
module triangle_face_normal
  import tfn_pkg::*;
#(
  parameter int COORD_FRAC_BITS  = 16,
  parameter int NORMAL_FRAC_BITS = 30
) (
  input  logic                 clk,
  input  logic                 rst,
  tfn_stream_if.sink           vertices,
  tfn_stream_if.source         normal,
  input  logic                 cfg_we,
  input  logic [MIN_LEN_W-1:0] cfg_wdata
);

  // Rescaling of the raw cross product to the output format.
  localparam int SH   = 2 * COORD_FRAC_BITS - NORMAL_FRAC_BITS;
  localparam int SHR  = (SH > 0) ? SH : 0;
  localparam int LSH  = (SH < 0) ? -SH : 0;
  localparam int RAWW = MAG_W + LSH + 1;
  localparam logic [RAWW-1:0] RND = (RAWW'(SHR > 0) << SHR) >> 1;

  // Divider: one quotient bit per stage.
  localparam int QW        = NORMAL_FRAC_BITS + 1;
  localparam int DIV_STEPS = NORMAL_FRAC_BITS + 1;

  typedef struct packed {
    logic [MAG_W-1:0] mag;
    logic             neg;
    logic [OUT_W-1:0] raw;
  } cm_t;

  typedef struct packed {
    logic [SUMSQ_W-1:0] rad;
    logic [SREM_W-1:0]  rem;
    logic [ROOT_W-1:0]  root;
    cm_t [2:0]          cm;
  } sq_t;

  typedef struct packed {
    logic [ROOT_W-1:0]           len;
    logic                        unit;
    logic [2:0]                  neg;
    logic [2:0][OUT_W-1:0]       raw;
    logic [2:0]                  lsb;
    logic [2:0][DREM_W-1:0]      rem;
    logic [2:0][QW-1:0]          q;
  } dv_t;

  // Raw cross product magnitude rescaled, rounded and saturated.
  function automatic logic [OUT_W-1:0] raw_fn(input logic [MAG_W-1:0] m, input logic ng);
    logic [RAWW-1:0] t;
    logic            ovf;
    logic [OUT_W-1:0] r;
    t   = ((RAWW'(m) << LSH) + RND) >> SHR;
    ovf = |t[RAWW-1:OUT_W-1];
    if (ng) begin
      r = ovf ? {1'b1, {(OUT_W-1){1'b0}}} : (~t[OUT_W-1:0] + OUT_W'(1));
    end else begin
      r = ovf ? {1'b0, {(OUT_W-1){1'b1}}} : t[OUT_W-1:0];
    end
    return r;
  endfunction

  logic [MIN_LEN_W-1:0] min_length;
  logic                 adv;
  logic                 out_valid;
  norm_t                out_data;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      min_length <= MIN_LENGTH_RESET;
    end else if (cfg_we) begin
      min_length <= cfg_wdata;
    end
  end

  // The pipeline moves whenever the output register is free or being taken.
  assign adv            = !out_valid || normal.ready;
  assign vertices.ready = adv;
  assign normal.valid   = out_valid;
  assign normal.data    = out_data;

  logic [COORD_W-1:0] va [3];
  logic [COORD_W-1:0] vb [3];
  logic [COORD_W-1:0] vc [3];

  assign va[0] = vertices.data.a_x;
  assign va[1] = vertices.data.a_y;
  assign va[2] = vertices.data.a_z;
  assign vb[0] = vertices.data.b_x;
  assign vb[1] = vertices.data.b_y;
  assign vb[2] = vertices.data.b_z;
  assign vc[0] = vertices.data.c_x;
  assign vc[1] = vertices.data.c_y;
  assign vc[2] = vertices.data.c_z;

  logic                       v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
  logic signed [DIFF_W-1:0]   e1 [3];
  logic signed [DIFF_W-1:0]   e2 [3];
  logic signed [PROD_W-1:0]   pr [6];
  logic [CROSS_W-1:0]         cr [3];
  logic [MAG_W-1:0]           mag4 [3];
  logic [2:0]                 neg4;
  logic [2*HI_W-1:0]          hh [3];
  logic [HI_W+LO_W-1:0]       hl [3];
  logic [2*LO_W-1:0]          ll [3];
  cm_t [2:0]                  cm5, cm6, cm7;
  logic [SUMSQ_W-1:0]         sq [3];
  logic [SUMSQ_W-1:0]         s01;
  logic [SUMSQ_W-1:0]         sq2;
  sq_t                        sq_st [SQRT_STEPS+1];
  logic                       sq_v  [SQRT_STEPS+1];
  dv_t                        dv_st [DIV_STEPS+1];
  logic                       dv_v  [DIV_STEPS+1];

  // Valid bits of the front stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      v_s1 <= 1'b0;
      v_s2 <= 1'b0;
      v_s3 <= 1'b0;
      v_s4 <= 1'b0;
      v_s5 <= 1'b0;
      v_s6 <= 1'b0;
      v_s7 <= 1'b0;
      sq_v[0] <= 1'b0;
    end else if (adv) begin
      v_s1 <= vertices.valid;
      v_s2 <= v_s1;
      v_s3 <= v_s2;
      v_s4 <= v_s3;
      v_s5 <= v_s4;
      v_s6 <= v_s5;
      v_s7 <= v_s6;
      sq_v[0] <= v_s7;
    end
  end

  // Front stages: edges, products, cross product, magnitude, squares, sum.
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        e1[i] <= {va[i][COORD_W-1], va[i]} - {vb[i][COORD_W-1], vb[i]};
        e2[i] <= {vc[i][COORD_W-1], vc[i]} - {vb[i][COORD_W-1], vb[i]};
      end

      pr[0] <= e2[1] * e1[2];
      pr[1] <= e2[2] * e1[1];
      pr[2] <= e2[2] * e1[0];
      pr[3] <= e2[0] * e1[2];
      pr[4] <= e2[0] * e1[1];
      pr[5] <= e2[1] * e1[0];

      for (int i = 0; i < 3; i++) begin
        cr[i] <= {pr[2*i][PROD_W-1], pr[2*i]} - {pr[2*i+1][PROD_W-1], pr[2*i+1]};
      end

      for (int i = 0; i < 3; i++) begin
        neg4[i] <= cr[i][CROSS_W-1];
        mag4[i] <= cr[i][CROSS_W-1] ? MAG_W'(~cr[i] + CROSS_W'(1)) : MAG_W'(cr[i]);
      end

      // Square split into high and low slices; raw output formed here too.
      for (int i = 0; i < 3; i++) begin
        hh[i]      <= mag4[i][MAG_W-1:LO_W] * mag4[i][MAG_W-1:LO_W];
        hl[i]      <= mag4[i][MAG_W-1:LO_W] * mag4[i][LO_W-1:0];
        ll[i]      <= mag4[i][LO_W-1:0] * mag4[i][LO_W-1:0];
        cm5[i].mag <= mag4[i];
        cm5[i].neg <= neg4[i];
        cm5[i].raw <= raw_fn(mag4[i], neg4[i]);
      end

      for (int i = 0; i < 3; i++) begin
        sq[i] <= SUMSQ_W'({hh[i], {(2*LO_W){1'b0}}}) + SUMSQ_W'({hl[i], {(LO_W+1){1'b0}}})
               + SUMSQ_W'(ll[i]);
      end
      cm6 <= cm5;

      s01 <= sq[0] + sq[1];
      sq2 <= sq[2];
      cm7 <= cm6;

      sq_st[0].rad  <= s01 + sq2;
      sq_st[0].rem  <= '0;
      sq_st[0].root <= '0;
      sq_st[0].cm   <= cm7;
    end
  end

  // Square root: one restoring step per stage, two radicand bits each.
  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
    logic [SREM_W-1:0] cur;
    logic [SREM_W-1:0] trial;
    logic              geq;

    assign cur   = {sq_st[k].rem[SREM_W-3:0], sq_st[k].rad[SUMSQ_W-1 -: 2]};
    assign trial = {1'b0, sq_st[k].root, 2'b01};
    assign geq   = cur >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        sq_v[k+1] <= 1'b0;
      end else if (adv) begin
        sq_v[k+1] <= sq_v[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        sq_st[k+1].rad  <= sq_st[k].rad << 2;
        sq_st[k+1].rem  <= geq ? (cur - trial) : cur;
        sq_st[k+1].root <= {sq_st[k].root[ROOT_W-2:0], geq};
        sq_st[k+1].cm   <= sq_st[k].cm;
      end
    end
  end

  // Threshold test and divider setup.
  logic [ROOT_W-1:0] len_sq;
  assign len_sq = sq_st[SQRT_STEPS].root;

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_v[0] <= 1'b0;
    end else if (adv) begin
      dv_v[0] <= sq_v[SQRT_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dv_st[0].len  <= len_sq;
      dv_st[0].unit <= (|len_sq) && (len_sq >= ROOT_W'(min_length));
      for (int i = 0; i < 3; i++) begin
        dv_st[0].neg[i] <= sq_st[SQRT_STEPS].cm[i].neg;
        dv_st[0].raw[i] <= sq_st[SQRT_STEPS].cm[i].raw;
        dv_st[0].lsb[i] <= sq_st[SQRT_STEPS].cm[i].mag[0];
        dv_st[0].rem[i] <= DREM_W'(sq_st[SQRT_STEPS].cm[i].mag >> 1);
        dv_st[0].q[i]   <= '0;
      end
    end
  end

  // Divider: magnitude scaled to the output format over the length, one bit a stage.
  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
    logic [DREM_W:0] cur [3];
    logic [2:0]      geq;

    for (genvar i = 0; i < 3; i++) begin : g_lane
      assign cur[i] = {dv_st[j].rem[i], (j == 0) ? dv_st[j].lsb[i] : 1'b0};
      assign geq[i] = cur[i] >= {2'b00, dv_st[j].len};
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        dv_v[j+1] <= 1'b0;
      end else if (adv) begin
        dv_v[j+1] <= dv_v[j];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        dv_st[j+1].len  <= dv_st[j].len;
        dv_st[j+1].unit <= dv_st[j].unit;
        dv_st[j+1].neg  <= dv_st[j].neg;
        dv_st[j+1].raw  <= dv_st[j].raw;
        dv_st[j+1].lsb  <= dv_st[j].lsb;
        for (int i = 0; i < 3; i++) begin
          dv_st[j+1].rem[i] <= geq[i] ? DREM_W'(cur[i] - {2'b00, dv_st[j].len})
                                      : DREM_W'(cur[i]);
          dv_st[j+1].q[i]   <= {dv_st[j].q[i][QW-2:0], geq[i]};
        end
      end
    end
  end

  // Rounding, sign and selection between unit and raw normal.
  logic [OUT_W-1:0] res [3];
  dv_t              dv_last;
  assign dv_last = dv_st[DIV_STEPS];

  for (genvar i = 0; i < 3; i++) begin : g_out
    logic             rnd;
    logic [QW:0]      qr;
    logic [OUT_W-1:0] qv;

    assign rnd = {dv_last.rem[i], 1'b0} >= {2'b00, dv_last.len};
    assign qr  = (QW+1)'(dv_last.q[i]) + (QW+1)'(rnd);
    assign qv  = OUT_W'(qr);
    assign res[i] = !dv_last.unit ? dv_last.raw[i]
                  : (dv_last.neg[i] ? (~qv + OUT_W'(1)) : qv);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= dv_v[DIV_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data.normal_x   <= res[0];
      out_data.normal_y   <= res[1];
      out_data.normal_z   <= res[2];
      out_data.normalized <= dv_last.unit;
    end
  end

endmodule

### bench/triangle_face_normal_tb.sv
// Testbench for triangle_face_normal: random and directed triangles against a bit-exact predictor.
// Depends on rtl/tfn_pkg.sv, rtl/tfn_stream_if.sv and rtl/triangle_face_normal.sv.
`timescale 1ns / 100ps

module triangle_face_normal_tb;
  import tfn_pkg::*;

  localparam int CFB    = 16;
  localparam int NFB    = 30;
  localparam int SHIFT  = 2 * CFB - NFB;
  localparam int LAT    = 77 + NFB;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [MIN_LEN_W-1:0] cfg_wdata = '0;

  tfn_stream_if #(.payload_t(tri_t))  vin ();
  tfn_stream_if #(.payload_t(norm_t)) nout ();

  triangle_face_normal u_dut (
    .clk(clk), .rst(rst), .vertices(vin), .normal(nout),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always #2 clk = ~clk;

  tri_t  tri_q[$];
  norm_t normal_q[$];
  logic [31:0] min_len_shadow = MIN_LENGTH_RESET;
  int errors = 0;
  logic in_taken = 1'b0;
  int in_gap = 0;
  int out_gap = 0;
  bit no_idle = 1'b0;

  initial begin
    vin.valid = 1'b0;
    vin.data = '0;
    nout.ready = 1'b0;
  end

  // Mostly short gaps, a few long ones; none at all in burst phases.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Exact cross product, floor square root, rounded division and saturation.
  function automatic norm_t face_normal(tri_t t, logic [31:0] thr);
    logic signed [33:0] e1[3];
    logic signed [33:0] e2[3];
    logic signed [69:0] cr[3];
    logic [69:0] mg[3];
    logic neg[3];
    logic [139:0] sq, num, q, rm, den;
    logic [69:0] root, trial;
    logic unit;
    logic [31:0] comp[3];
    norm_t res;
    e1[0] = 34'(t.a_x) - 34'(t.b_x);
    e1[1] = 34'(t.a_y) - 34'(t.b_y);
    e1[2] = 34'(t.a_z) - 34'(t.b_z);
    e2[0] = 34'(t.c_x) - 34'(t.b_x);
    e2[1] = 34'(t.c_y) - 34'(t.b_y);
    e2[2] = 34'(t.c_z) - 34'(t.b_z);
    cr[0] = 70'(e2[1]) * 70'(e1[2]) - 70'(e2[2]) * 70'(e1[1]);
    cr[1] = 70'(e2[2]) * 70'(e1[0]) - 70'(e2[0]) * 70'(e1[2]);
    cr[2] = 70'(e2[0]) * 70'(e1[1]) - 70'(e2[1]) * 70'(e1[0]);
    sq = '0;
    for (int i = 0; i < 3; i++) begin
      neg[i] = cr[i][69];
      mg[i] = neg[i] ? 70'(-cr[i]) : 70'(cr[i]);
      sq = sq + 140'(mg[i]) * 140'(mg[i]);
    end
    root = '0;
    for (int b = 69; b >= 0; b--) begin
      trial = root | (70'(1) << b);
      if (140'(trial) * 140'(trial) <= sq) root = trial;
    end
    unit = (root != 0) && (root >= 70'(thr));
    den = 140'(root);
    for (int i = 0; i < 3; i++) begin
      if (unit) begin
        num = 140'(mg[i]) << NFB;
        q = num / den;
        rm = num % den;
        if ((rm << 1) >= den) q = q + 1;
      end else if (SHIFT > 0) begin
        q = (140'(mg[i]) + (140'(1) << (SHIFT - 1))) >> SHIFT;
      end else begin
        q = 140'(mg[i]) << (-SHIFT);
      end
      if (neg[i]) begin
        comp[i] = (q >= 140'h80000000) ? 32'h80000000 : 32'(-q[31:0]);
      end else begin
        comp[i] = (q > 140'h7FFFFFFF) ? 32'h7FFFFFFF : q[31:0];
      end
    end
    res.normal_x = comp[0];
    res.normal_y = comp[1];
    res.normal_z = comp[2];
    res.normalized = unit;
    return res;
  endfunction

  // Input driver: next triangle after each accepted transaction, with random gaps.
  always @(negedge clk) begin
    if (!rst && (!vin.valid || in_taken)) begin
      if (in_gap > 0) begin
        vin.valid <= 1'b0;
        in_gap <= in_gap - 1;
      end else if (tri_q.size() > 0) begin
        vin.data <= tri_q.pop_front();
        vin.valid <= 1'b1;
        in_gap <= pick_gap();
      end else begin
        vin.valid <= 1'b0;
      end
    end
  end

  // Output stall generator.
  always @(negedge clk) begin
    if (rst) begin
      nout.ready <= 1'b0;
    end else if (out_gap > 0) begin
      nout.ready <= 1'b0;
      out_gap <= out_gap - 1;
    end else begin
      nout.ready <= 1'b1;
      out_gap <= pick_gap();
    end
  end

  // Monitor: predict on each input transaction, check each output transaction.
  always @(posedge clk) begin
    norm_t want;
    norm_t got;
    in_taken <= vin.valid && vin.ready && !rst;
    if (!rst && vin.valid && vin.ready) normal_q.push_back(face_normal(vin.data, min_len_shadow));
    if (!rst && nout.valid && nout.ready) begin
      got = nout.data;
      if (normal_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected normal %h %h %h flag %b", $realtime,
                 got.normal_x, got.normal_y, got.normal_z, got.normalized);
      end else begin
        want = normal_q.pop_front();
        if (got.normal_x !== want.normal_x) begin
          errors++;
          $display("%0t: normal_x expected %h actual %h", $realtime, want.normal_x, got.normal_x);
        end
        if (got.normal_y !== want.normal_y) begin
          errors++;
          $display("%0t: normal_y expected %h actual %h", $realtime, want.normal_y, got.normal_y);
        end
        if (got.normal_z !== want.normal_z) begin
          errors++;
          $display("%0t: normal_z expected %h actual %h", $realtime, want.normal_z, got.normal_z);
        end
        if (got.normalized !== want.normalized) begin
          errors++;
          $display("%0t: normalized expected %b actual %b", $realtime,
                   want.normalized, got.normalized);
        end
      end
    end
  end

  function automatic tri_t make_tri(int a_x, int a_y, int a_z, int b_x, int b_y, int b_z,
                                    int c_x, int c_y, int c_z);
    tri_t t;
    t.a_x = a_x; t.a_y = a_y; t.a_z = a_z;
    t.b_x = b_x; t.b_y = b_y; t.b_z = b_z;
    t.c_x = c_x; t.c_y = c_y; t.c_z = c_z;
    return t;
  endfunction

  // Random triangle: either fully random vertices or a random corner with edges of random scale.
  function automatic tri_t rand_tri();
    tri_t t;
    int s1, s2;
    if ($urandom_range(0, 9) < 3) begin
      t = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
           $urandom, $urandom, $urandom};
    end else begin
      s1 = $urandom_range(0, 31);
      s2 = $urandom_range(0, 31);
      t.b_x = $urandom; t.b_y = $urandom; t.b_z = $urandom;
      t.a_x = t.b_x + ($signed($urandom) >>> (31 - s1));
      t.a_y = t.b_y + ($signed($urandom) >>> (31 - s1));
      t.a_z = t.b_z + ($signed($urandom) >>> (31 - s1));
      t.c_x = t.b_x + ($signed($urandom) >>> (31 - s2));
      t.c_y = t.b_y + ($signed($urandom) >>> (31 - s2));
      t.c_z = t.b_z + ($signed($urandom) >>> (31 - s2));
    end
    return t;
  endfunction

  task automatic write_min_length(logic [31:0] value);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we = 1'b0;
    min_len_shadow = value;
  endtask

  task automatic drain();
    while (tri_q.size() > 0 || normal_q.size() > 0 || vin.valid) @(posedge clk);
  endtask

  task automatic run_random(int count, bit burst);
    no_idle = burst;
    for (int i = 0; i < count; i++) tri_q.push_back(rand_tri());
    drain();
    no_idle = 1'b0;
  endtask

  // Main sequence: reset, directed cases, then random phases at several thresholds.
  initial begin
    int mx, mn;
    mx = 32'sh7FFFFFFF;
    mn = 32'sh80000000;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Degenerate, collinear, extremes and the threshold boundary at the reset value.
    tri_q.push_back(make_tri(0, 0, 0, 0, 0, 0, 0, 0, 0));
    tri_q.push_back(make_tri(5, 5, 5, 5, 5, 5, 5, 5, 5));
    tri_q.push_back(make_tri(2, 4, 6, 0, 0, 0, 1, 2, 3));
    tri_q.push_back(make_tri(207, 0, 0, 0, 0, 0, 0, 207, 0));
    tri_q.push_back(make_tri(208, 0, 0, 0, 0, 0, 0, 208, 0));
    tri_q.push_back(make_tri(1, 0, 0, 0, 0, 0, 0, 1, 0));
    tri_q.push_back(make_tri(0, 1, 0, 0, 0, 0, 1, 0, 0));
    tri_q.push_back(make_tri(mx, mn, mx, mn, mx, mn, mx, mx, mx));
    tri_q.push_back(make_tri(mx, mx, mx, mn, mn, mn, mn, mx, mx));
    tri_q.push_back(make_tri(mx, mn, mn, mn, mn, mn, mn, mx, mn));
    tri_q.push_back(make_tri(mn, mx, mx, mx, mx, mx, mx, mn, mx));
    tri_q.push_back(make_tri(mx, mx, mx, mx, mx, mx, mx, mx, mx));
    tri_q.push_back(make_tri(-1, -1, -1, 0, 0, 0, 1, -1, 0));
    tri_q.push_back(make_tri(32'h10000, 0, 0, 0, 0, 0, 0, 32'h10000, 0));
    tri_q.push_back(make_tri(3, 1, 0, 0, 0, 0, 1, 3, 1));
    tri_q.push_back(make_tri(1, 1, 1, 0, 0, 0, 1, -1, 2));
    drain();
    run_random(100, 1'b0);

    // Threshold zero: every nondegenerate triangle is normalized.
    write_min_length(32'd0);
    tri_q.push_back(make_tri(0, 0, 0, 0, 0, 0, 0, 0, 0));
    tri_q.push_back(make_tri(1, 0, 0, 0, 0, 0, 0, 1, 0));
    tri_q.push_back(make_tri(2, 0, 0, 1, 0, 0, 1, 1, 0));
    drain();
    run_random(100, 1'b1);

    // Largest threshold.
    write_min_length(32'hFFFFFFFF);
    tri_q.push_back(make_tri(32'h10000, 0, 0, 0, 0, 0, 0, 32'hFFFF, 0));
    tri_q.push_back(make_tri(32'h10000, 0, 0, 0, 0, 0, 0, 32'h10000, 0));
    drain();
    run_random(100, 1'b0);

    write_min_length($urandom_range(1, 1 << 20));
    run_random(100, 1'b0);

    write_min_length($urandom);
    run_random(100, 1'b0);

    repeat (LAT + 20) @(posedge clk);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #5000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

### sim.f
rtl/tfn_pkg.sv
rtl/tfn_stream_if.sv
rtl/triangle_face_normal.sv
bench/triangle_face_normal_tb.sv
